// ----- sv/hsvled_pkg.sv -----
// Package for the HSV to RGB LED drive pipeline.
// Holds the widths, constants, hue sector codes and per-stage word types.
// No dependencies.
package hsvled_pkg;

  localparam int unsigned HUE_W    = 9;
  localparam int unsigned CH_W     = 8;
  localparam int unsigned SECTOR_W = 4;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned PROD_W   = 14;
  localparam int unsigned NUM_THR  = 8;

  localparam logic [HUE_W-1:0] SECTOR_DEG  = 9'd60;
  localparam logic [CH_W-1:0]  CH_MAX      = 8'hFF;

  // floor(p / 60) == (p * RECIP_60) >> RECIP_SHIFT for every p below 2**PROD_W.
  localparam logic [14:0]      RECIP_60    = 15'd17477;
  localparam int unsigned      RECIP_SHIFT = 20;
  localparam int unsigned      RECIP_PW    = PROD_W + 15;

  typedef enum logic [SECTOR_W-1:0] {
    SEC_RED_GREEN_UP  = 4'd0,
    SEC_RED_DOWN      = 4'd1,
    SEC_BLUE_UP       = 4'd2,
    SEC_GREEN_DOWN    = 4'd3,
    SEC_RED_UP        = 4'd4,
    SEC_BLUE_DOWN     = 4'd5,
    SEC_OUT_OF_RANGE6 = 4'd6,
    SEC_OUT_OF_RANGE7 = 4'd7,
    SEC_OUT_OF_RANGE8 = 4'd8
  } sector_e;

  // Stage 1 word: sector, position inside it and the floor level.
  typedef struct packed {
    sector_e            sector;
    logic [POS_W-1:0]   pos;
    logic [CH_W-1:0]    val;
    logic [CH_W-1:0]    fl;
    logic               gray;
  } s1_t;

  // Stage 2 word: the rising and falling ramp products.
  typedef struct packed {
    sector_e            sector;
    logic [PROD_W-1:0]  prod_up;
    logic [PROD_W-1:0]  prod_dn;
    logic [CH_W-1:0]    val;
    logic [CH_W-1:0]    fl;
    logic               gray;
  } s2_t;

  // Stage 3 word: finished ramp levels.
  typedef struct packed {
    sector_e            sector;
    logic [CH_W-1:0]    up;
    logic [CH_W-1:0]    dn;
    logic [CH_W-1:0]    val;
    logic [CH_W-1:0]    fl;
    logic               gray;
  } s3_t;

  // Start of each sector in degrees.
  function automatic logic [HUE_W-1:0] sector_base(input sector_e s);
    logic [HUE_W-1:0] b;
    case (s)
      SEC_RED_GREEN_UP:  b = 9'd0;
      SEC_RED_DOWN:      b = 9'd60;
      SEC_BLUE_UP:       b = 9'd120;
      SEC_GREEN_DOWN:    b = 9'd180;
      SEC_RED_UP:        b = 9'd240;
      SEC_BLUE_DOWN:     b = 9'd300;
      SEC_OUT_OF_RANGE6: b = 9'd360;
      SEC_OUT_OF_RANGE7: b = 9'd420;
      SEC_OUT_OF_RANGE8: b = 9'd480;
      default:           b = 9'd0;
    endcase
    return b;
  endfunction

endpackage

// ----- sv/hsv_to_rgb_led_drive.sv -----
// HSV to RGB conversion for LED drive, top level.
// One color accepted every cycle, with done_o marking each finished color.
// Stages: sector split and floor multiply, ramp multiplies, divide by 60
// by reciprocal, then channel selection and inversion into the output register.
// busy is always low since results cannot be held off. Reset clears the
// valid bits and sets invert_q to 1. Depends on hsvled_pkg.
module hsv_to_rgb_led_drive (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [hsvled_pkg::HUE_W-1:0] hue_deg_i,
  input  logic [hsvled_pkg::CH_W-1:0]  saturation_i,
  input  logic [hsvled_pkg::CH_W-1:0]  brightness_i,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic                        cfg_data_i,
  output logic                        done_o,
  output logic [hsvled_pkg::CH_W-1:0]  red_level_o,
  output logic [hsvled_pkg::CH_W-1:0]  green_level_o,
  output logic [hsvled_pkg::CH_W-1:0]  blue_level_o
);
  import hsvled_pkg::*;

  logic invert_q;
  logic s1_valid_q, s2_valid_q, s3_valid_q, done_q;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  s3_t  s3_d, s3_q;
  logic [CH_W-1:0] r_d, g_d, b_d, r_q, g_q, b_q;

  logic [SECTOR_W-1:0] sec_cnt;
  logic [HUE_W-1:0]    pos_full;
  logic [2*CH_W-1:0]   fl_prod;
  logic [CH_W-1:0]     diff;
  logic [POS_W-1:0]    pos_dn;
  logic [RECIP_PW-1:0] q_up, q_dn;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      invert_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      invert_q <= cfg_data_i;
    end
  end

  // Stage 1: sector by threshold compares, position, floor level.
  always_comb begin
    sec_cnt = '0;
    for (int i = 1; i <= NUM_THR; i++) begin
      if (hue_deg_i >= HUE_W'(i * 60)) begin
        sec_cnt = SECTOR_W'(i);
      end
    end
    pos_full    = hue_deg_i - sector_base(sector_e'(sec_cnt));
    fl_prod     = (CH_MAX - saturation_i) * brightness_i;
    s1_d.sector = sector_e'(sec_cnt);
    s1_d.pos    = pos_full[POS_W-1:0];
    s1_d.val    = brightness_i;
    s1_d.fl     = fl_prod[2*CH_W-1:CH_W];
    s1_d.gray   = (saturation_i == '0);
  end

  // Stage 2: the floor never exceeds the value, so the difference is unsigned.
  always_comb begin
    diff         = s1_q.val - s1_q.fl;
    pos_dn       = POS_W'(SECTOR_DEG) - s1_q.pos;
    s2_d.sector  = s1_q.sector;
    s2_d.prod_up = PROD_W'(diff) * PROD_W'(s1_q.pos);
    s2_d.prod_dn = PROD_W'(diff) * PROD_W'(pos_dn);
    s2_d.val     = s1_q.val;
    s2_d.fl      = s1_q.fl;
    s2_d.gray    = s1_q.gray;
  end

  // Stage 3: truncating divide by 60 through the reciprocal, plus the floor level.
  always_comb begin
    q_up        = RECIP_PW'(s2_q.prod_up) * RECIP_PW'(RECIP_60);
    q_dn        = RECIP_PW'(s2_q.prod_dn) * RECIP_PW'(RECIP_60);
    s3_d.sector = s2_q.sector;
    s3_d.up     = s2_q.fl + q_up[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
    s3_d.dn     = s2_q.fl + q_dn[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
    s3_d.val    = s2_q.val;
    s3_d.fl     = s2_q.fl;
    s3_d.gray   = s2_q.gray;
  end

  // Stage 4: place value, floor and ramp on the channels, then invert.
  always_comb begin
    r_d = '0;
    g_d = '0;
    b_d = '0;
    if (s3_q.gray) begin
      r_d = s3_q.val;
      g_d = s3_q.val;
      b_d = s3_q.val;
    end else begin
      case (s3_q.sector)
        SEC_RED_GREEN_UP: begin
          r_d = s3_q.val; g_d = s3_q.up;  b_d = s3_q.fl;
        end
        SEC_RED_DOWN: begin
          r_d = s3_q.dn;  g_d = s3_q.val; b_d = s3_q.fl;
        end
        SEC_BLUE_UP: begin
          r_d = s3_q.fl;  g_d = s3_q.val; b_d = s3_q.up;
        end
        SEC_GREEN_DOWN: begin
          r_d = s3_q.fl;  g_d = s3_q.dn;  b_d = s3_q.val;
        end
        SEC_RED_UP: begin
          r_d = s3_q.up;  g_d = s3_q.fl;  b_d = s3_q.val;
        end
        SEC_BLUE_DOWN: begin
          r_d = s3_q.val; g_d = s3_q.fl;  b_d = s3_q.dn;
        end
        default: begin
          r_d = '0; g_d = '0; b_d = '0;
        end
      endcase
    end
    if (invert_q) begin
      r_d = CH_MAX - r_d;
      g_d = CH_MAX - g_d;
      b_d = CH_MAX - b_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      s1_valid_q <= start && !busy;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      done_q     <= s3_valid_q;
    end
  end

  // Payload registers load only with a valid word behind them.
  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      s1_q <= s1_d;
    end
    if (s1_valid_q) begin
      s2_q <= s2_d;
    end
    if (s2_valid_q) begin
      s3_q <= s3_d;
    end
    if (s3_valid_q) begin
      r_q <= r_d;
      g_q <= g_d;
      b_q <= b_d;
    end
  end

  assign done_o        = done_q;
  assign red_level_o   = r_q;
  assign green_level_o = g_q;
  assign blue_level_o  = b_q;

endmodule

// ----- sv/hsvled_check.sv -----
// Port-level checker for hsv_to_rgb_led_drive, bound to the top level.
// Checks latency, busy, gray and out-of-range colors. Depends on hsvled_pkg.
module hsvled_check (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic [hsvled_pkg::HUE_W-1:0] hue_deg_i,
  input logic [hsvled_pkg::CH_W-1:0]  saturation_i,
  input logic                        done_o,
  input logic [hsvled_pkg::CH_W-1:0]  red_level_o,
  input logic [hsvled_pkg::CH_W-1:0]  green_level_o,
  input logic [hsvled_pkg::CH_W-1:0]  blue_level_o
);
  import hsvled_pkg::*;

  // Every accepted word comes out through the s1, s2, s3 and output registers.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == ($past(start && !busy && rst_ni, 4) && $past(rst_ni, 3)
               && $past(rst_ni, 2) && $past(rst_ni, 1)))
    else $error("result strobe does not match accepted word");

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy)
    else $error("busy raised");

  // Zero saturation gives three equal channels.
  a_gray: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(saturation_i, 4) == '0) |->
      (red_level_o == green_level_o && green_level_o == blue_level_o))
    else $error("gray word has unequal channels");

  // A hue beyond the circle gives black, either polarity.
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(saturation_i, 4) != '0 && $past(hue_deg_i, 4) >= 9'd360) |->
      (red_level_o == green_level_o && green_level_o == blue_level_o &&
       (red_level_o == '0 || red_level_o == CH_MAX)))
    else $error("out-of-range hue is not black");

endmodule

bind hsv_to_rgb_led_drive hsvled_check u_hsvled_check (.*);
